// ===== rtl/core/ubh_pkg.sv =====
package ubh_pkg;

  // operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // configuration register indexes
  localparam logic REG_BIN_WIDTH   = 1'b0;
  localparam logic REG_BINS_IN_USE = 1'b1;

  localparam int CFG_W      = 31;
  localparam int FRAC_ONE   = 65536;
  localparam int FRAC_W     = 17;
  localparam int EDGE_W     = 39;
  localparam int USE_W      = 9;
  localparam int USE_RESET  = 256;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] sample;
    logic [7:0]         bin_index;
  } in_t;

  typedef struct packed {
    logic              placed;
    logic [7:0]        placed_bin;
    logic [31:0]       bin_count;
    logic [31:0]       total_count;
    logic [31:0]       overflow_count;
    logic [31:0]       underflow_count;
    logic [FRAC_W-1:0] bin_fraction;
    logic [FRAC_W-1:0] below_fraction;
    logic [FRAC_W-1:0] from_fraction;
    logic [EDGE_W-1:0] low_edge;
    logic [EDGE_W-1:0] high_edge;
  } out_t;

  // saturating increment of a 32-bit counter
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    logic [31:0] r;
    r = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    return r;
  endfunction

endpackage

// ===== rtl/core/ubh_div.sv =====
module ubh_div #(
  parameter int DW = 56
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [31:0]   divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  import ubh_pkg::*;

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    work;
  logic [32:0]      rem;
  logic [31:0]      dsor;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [32:0]      rem_sh;
  logic             take;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem[31:0], work[DW-1]};
  assign take   = rem_sh >= {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW);
        work <= dividend;
        dsor <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem  <= take ? rem_sh - {1'b0, dsor} : rem_sh;
        work <= {work[DW-2:0], take};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = work;

endmodule

// ===== rtl/core/ubh_store.sv =====
module ubh_store #(
  parameter int BINS = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  logic [$clog2(BINS)-1:0] rd_addr,
  output logic [31:0]             rd_data,
  input  logic                    wr_en,
  input  logic [$clog2(BINS)-1:0] wr_addr,
  input  logic [31:0]             wr_data,
  output logic                    cleared
);
  import ubh_pkg::*;

  localparam int AW = $clog2(BINS);

  logic [31:0] mem [BINS];
  logic [AW:0] clr_cnt;

  assign cleared = (clr_cnt == (AW + 1)'(BINS));

  // clearing pass after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (!cleared) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (!cleared) begin
      mem[clr_cnt[AW-1:0]] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/uniform_bin_histogram_unit.sv =====
// channel  | direction | signals                       | content
// in       | input     | in_valid, in_ready, in_data   | add or read request
// out      | output    | out_valid, out_ready, out_data | one result per request
// cfg      | input     | cfg_wen, cfg_index, cfg_data  | bin_width, bins_in_use
// after reset the bin store is cleared entry by entry; no request is taken meanwhile
// an add with a non-negative sample goes through the bit-serial divider (DW = 48 + log2(BINS))
// a read does one store read for the asked bin and one per used bin, then, when total is
// nonzero, three fractions through the same divider
// a finished result waits in the output register; the next request is taken meanwhile
module uniform_bin_histogram_unit #(
  parameter int BINS = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ubh_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ubh_pkg::out_t  out_data,
  input  logic           cfg_wen,
  input  logic           cfg_index,
  input  logic [30:0]    cfg_data
);
  import ubh_pkg::*;

  localparam int AW   = $clog2(BINS);
  localparam int CW   = $clog2(BINS + 1);
  localparam int SUMW = 32 + AW;
  localparam int DW   = SUMW + 16;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADIV = 4'd1;
  localparam logic [3:0] S_ARD  = 4'd2;
  localparam logic [3:0] S_AWR  = 4'd3;
  localparam logic [3:0] S_RCNT = 4'd4;
  localparam logic [3:0] S_SUM  = 4'd5;
  localparam logic [3:0] S_FST  = 4'd6;
  localparam logic [3:0] S_FWT  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]        state;
  logic [CFG_W-1:0]  bin_width;
  logic [USE_W-1:0]  bins_in_use;
  logic [31:0]       total, over, under;

  // latched request
  logic [7:0]        idx;
  logic [31:0]       w;
  logic [CW-1:0]     used;
  logic              idx_ok;

  // result under construction
  logic              placed;
  logic [7:0]        pbin;
  logic [31:0]       cnt;
  logic [SUMW-1:0]   below, from;
  logic [FRAC_W-1:0] fb, fbelow, ffrom;
  logic [EDGE_W-1:0] lo, hi;
  logic [AW-1:0]     target;

  // sweep
  logic [CW-1:0]     j;
  logic              pend;
  logic [AW-1:0]     jd;
  logic [1:0]        fsel;

  // store and divider
  logic              rd_en, wr_en, cleared;
  logic [AW-1:0]     rd_addr;
  logic [31:0]       rd_data;
  logic              dv_start, dv_done;
  logic [DW-1:0]     dv_dividend, dv_q;
  logic [31:0]       dv_divisor;
  logic [SUMW-1:0]   part;
  logic [FRAC_W-1:0] fq;
  logic              out_free;

  ubh_store #(.BINS(BINS)) u_store (
    .clk, .rst, .rd_en, .rd_addr, .rd_data,
    .wr_en, .wr_addr(target), .wr_data(sat_inc(rd_data)), .cleared
  );

  ubh_div #(.DW(DW)) u_div (
    .clk, .rst, .start(dv_start), .dividend(dv_dividend), .divisor(dv_divisor),
    .done(dv_done), .quotient(dv_q)
  );

  assign in_ready = (state == S_IDLE) && cleared;
  assign out_free = !out_valid || out_ready;

  // fraction operand and clamped quotient
  always_comb begin
    unique case (fsel)
      2'd0:    part = SUMW'(cnt);
      2'd1:    part = below;
      default: part = from;
    endcase
    fq = (dv_q > DW'(FRAC_ONE)) ? FRAC_W'(FRAC_ONE) : dv_q[FRAC_W-1:0];
  end

  // divider launch
  always_comb begin
    dv_start    = 1'b0;
    dv_dividend = {part, 16'd0};
    dv_divisor  = total;
    if (in_valid && in_ready && in_data.operation == OP_ADD && !in_data.sample[31]) begin
      dv_start    = 1'b1;
      dv_dividend = DW'(unsigned'(in_data.sample));
      dv_divisor  = (bin_width == '0) ? 32'd1 : 32'(bin_width);
    end else if (state == S_FST && total != '0) begin
      dv_start = 1'b1;
    end
  end

  // store read port and write enable
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = j[AW-1:0];
    wr_en   = (state == S_AWR);
    if (state == S_ADIV && dv_done) begin
      rd_en   = 1'b1;
      rd_addr = dv_q[AW-1:0];
    end else if (state == S_RCNT) begin
      rd_en   = 1'b1;
      rd_addr = AW'(idx);
    end else if (state == S_SUM && j < used) begin
      rd_en = 1'b1;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width   <= CFG_W'(1);
      bins_in_use <= USE_W'(USE_RESET);
    end else if (cfg_wen) begin
      if (cfg_index == REG_BIN_WIDTH) bin_width <= cfg_data;
      if (cfg_index == REG_BINS_IN_USE) bins_in_use <= cfg_data[USE_W-1:0];
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      total     <= '0;
      over      <= '0;
      under     <= '0;
      pend      <= 1'b0;
    end else begin
      // result register handshake
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            idx    <= in_data.bin_index;
            idx_ok <= 32'(in_data.bin_index) < 32'(BINS);
            w      <= (bin_width == '0) ? 32'd1 : 32'(bin_width);
            used   <= (32'(bins_in_use) > 32'(BINS)) ? CW'(BINS) : CW'(bins_in_use);
            placed <= 1'b0;
            pbin   <= '0;
            cnt    <= '0;
            below  <= '0;
            from   <= '0;
            fb     <= '0;
            fbelow <= '0;
            ffrom  <= '0;
            lo     <= '0;
            hi     <= '0;
            j      <= '0;
            pend   <= 1'b0;
            fsel   <= 2'd0;
            if (in_data.operation == OP_READ) begin
              state <= S_RCNT;
            end else if (in_data.sample[31]) begin
              under <= sat_inc(under);
              state <= S_DONE;
            end else begin
              state <= S_ADIV;
            end
          end
        end
        S_ADIV: begin
          if (dv_done) begin
            if (dv_q >= DW'(used)) begin
              over  <= sat_inc(over);
              state <= S_DONE;
            end else begin
              target <= dv_q[AW-1:0];
              state  <= S_ARD;
            end
          end
        end
        S_ARD: state <= S_AWR;
        S_AWR: begin
          total  <= sat_inc(total);
          placed <= 1'b1;
          pbin   <= 8'(target);
          state  <= S_DONE;
        end
        S_RCNT: begin
          lo    <= {7'd0, w} * EDGE_W'(idx);
          hi    <= {7'd0, w} * EDGE_W'({1'b0, idx} + 9'd1);
          state <= S_SUM;
        end
        S_SUM: begin
          // first cycle here brings the asked bin; later cycles the sweep
          if (j == '0 && !pend) begin
            cnt <= idx_ok ? rd_data : 32'd0;
          end
          if (pend) begin
            if (32'(jd) < 32'(idx)) below <= below + SUMW'(rd_data);
            else from <= from + SUMW'(rd_data);
          end
          pend <= j < used;
          jd   <= j[AW-1:0];
          if (j < used) j <= j + 1'b1;
          else if (!pend) state <= S_FST;
        end
        S_FST: state <= (total != '0) ? S_FWT : S_DONE;
        S_FWT: begin
          if (dv_done) begin
            unique case (fsel)
              2'd0:    fb     <= fq;
              2'd1:    fbelow <= fq;
              default: ffrom  <= fq;
            endcase
            fsel  <= fsel + 2'd1;
            state <= (fsel == 2'd2) ? S_DONE : S_FST;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data.placed          <= placed;
            out_data.placed_bin      <= pbin;
            out_data.bin_count       <= cnt;
            out_data.total_count     <= total;
            out_data.overflow_count  <= over;
            out_data.underflow_count <= under;
            out_data.bin_fraction    <= fb;
            out_data.below_fraction  <= fbelow;
            out_data.from_fraction   <= ffrom;
            out_data.low_edge        <= lo;
            out_data.high_edge       <= hi;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/uniform_bin_histogram_unit_tb.sv =====
module uniform_bin_histogram_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ubh_pkg::*;

  localparam int NBINS = 256;
  localparam int RANDOM_ITEMS = 880;
  localparam longint CYCLE_LIMIT = 64'd2_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_wen = 1'b0;
  logic cfg_index = REG_BIN_WIDTH;
  logic [30:0] cfg_data = '0;

  uniform_bin_histogram_unit #(.BINS(NBINS)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // histogram mirror
  logic [31:0] hist_bins [NBINS];
  logic [31:0] hist_placed, hist_over, hist_under;
  logic [30:0] width_reg;
  logic [8:0]  used_reg;

  out_t result_queue [$];
  int errors = 0;
  bit quiet = 1'b0;
  bit stim_done = 1'b0;
  longint cycles = 0;

  function automatic logic [16:0] q16_share(input logic [63:0] part, input logic [31:0] total);
    logic [63:0] q;
    if (total == 0) return '0;
    q = (part << 16) / {32'd0, total};
    return (q > 64'd65536) ? 17'd65536 : q[16:0];
  endfunction

  // apply one request to the mirror, return expected result
  function automatic out_t histogram_step(input in_t req);
    out_t r;
    logic [31:0] w, used, b;
    logic [63:0] below, above;
    r = '0;
    w = (width_reg == 0) ? 32'd1 : {1'b0, width_reg};
    used = (used_reg > NBINS) ? NBINS : {23'd0, used_reg};
    if (req.operation == OP_ADD) begin
      if (req.sample[31]) begin
        hist_under = sat_inc(hist_under);
      end else begin
        b = $unsigned(req.sample) / w;
        if (b >= used) begin
          hist_over = sat_inc(hist_over);
        end else begin
          hist_bins[b] = sat_inc(hist_bins[b]);
          hist_placed = sat_inc(hist_placed);
          r.placed = 1'b1;
          r.placed_bin = b[7:0];
        end
      end
    end else begin
      below = 0;
      above = 0;
      r.bin_count = hist_bins[req.bin_index];
      for (int j = 0; j < used; j++) begin
        if (j < req.bin_index) below += hist_bins[j];
        else above += hist_bins[j];
      end
      r.bin_fraction = q16_share({32'd0, r.bin_count}, hist_placed);
      r.below_fraction = q16_share(below, hist_placed);
      r.from_fraction = q16_share(above, hist_placed);
      r.low_edge = 39'(64'(w) * 64'(req.bin_index));
      r.high_edge = 39'(64'(w) * (64'(req.bin_index) + 64'd1));
    end
    r.total_count = hist_placed;
    r.overflow_count = hist_over;
    r.underflow_count = hist_under;
    return r;
  endfunction

  task automatic idle_burst();
    repeat ($urandom_range(1, 16)) @(posedge clk);
  endtask

  // drive one request and hold it until it is taken
  task automatic present(input in_t req);
    if (!quiet && $urandom_range(0, 5) == 0) idle_burst();
    in_data <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
  endtask

  task automatic send_request(input in_t req);
    present(req);
    result_queue.insert(result_queue.size(), histogram_step(req));
    @(posedge clk);
  endtask

  task automatic drain();
    while (result_queue.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == REG_BIN_WIDTH) width_reg = val;
    else used_reg = val[8:0];
    @(posedge clk);
  endtask

  // result checking
  task automatic check_field(input string name, input logic [63:0] exp_v, input logic [63:0] got);
    if (exp_v !== got) begin
      $error("%s expected %0h actual %0h", name, exp_v, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_t e;
    if (!rst && out_valid && out_ready) begin
      if (result_queue.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = result_queue.pop_front();
        check_field("placed", e.placed, out_data.placed);
        check_field("placed_bin", e.placed_bin, out_data.placed_bin);
        check_field("bin_count", e.bin_count, out_data.bin_count);
        check_field("total_count", e.total_count, out_data.total_count);
        check_field("overflow_count", e.overflow_count, out_data.overflow_count);
        check_field("underflow_count", e.underflow_count, out_data.underflow_count);
        check_field("bin_fraction", e.bin_fraction, out_data.bin_fraction);
        check_field("below_fraction", e.below_fraction, out_data.below_fraction);
        check_field("from_fraction", e.from_fraction, out_data.from_fraction);
        check_field("low_edge", e.low_edge, out_data.low_edge);
        check_field("high_edge", e.high_edge, out_data.high_edge);
      end
    end
  end

  // receiver stalls in bursts unless quiet is set
  initial begin
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (!quiet) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // directed table: operation, sample, index; check_now marks a typed-in result
  typedef struct {
    in_t  req;
    bit   check_now;
    out_t want;
  } row_t;

  function automatic in_t mk(input logic op, input logic [31:0] s, input logic [7:0] i);
    in_t r;
    r.operation = op;
    r.sample = s;
    r.bin_index = i;
    return r;
  endfunction

  function automatic out_t rd_empty(input logic [7:0] i);
    out_t r;
    r = '0;
    r.low_edge = 39'(i);
    r.high_edge = 39'(i) + 39'd1;
    return r;
  endfunction

  row_t table_rows [$];

  function automatic void add_row(input in_t req, input bit chk, input out_t want);
    row_t r;
    r.req = req;
    r.check_now = chk;
    r.want = want;
    table_rows.insert(table_rows.size(), r);
  endfunction

  task automatic run_table();
    out_t pred;
    foreach (table_rows[k]) begin
      if (table_rows[k].check_now) begin
        pred = histogram_step(table_rows[k].req);
        if (pred !== table_rows[k].want) begin
          $error("table row %0d disagrees with predictor", k);
          errors++;
        end
        // typed-in result is the one checked against the block
        present(table_rows[k].req);
        result_queue.insert(result_queue.size(), table_rows[k].want);
        @(posedge clk);
      end else begin
        send_request(table_rows[k].req);
      end
    end
  endtask

  function automatic in_t random_request(input int mode);
    in_t r;
    logic [31:0] s;
    int pick;
    r.operation = ($urandom_range(0, 3) == 0) ? OP_READ : OP_ADD;
    r.bin_index = (mode == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 15));
    pick = $urandom_range(0, 9);
    if (pick == 0) s = $urandom();
    else if (pick == 1) s = 32'h8000_0000 | $urandom();
    else if (pick == 2) s = {1'b0, 31'($urandom())};
    else s = 32'($urandom_range(0, 300) * ((width_reg == 0) ? 1 : width_reg) / 16);
    r.sample = s;
    return r;
  endfunction

  initial begin
    out_t w;
    for (int i = 0; i < NBINS; i++) hist_bins[i] = '0;
    hist_placed = '0; hist_over = '0; hist_under = '0;
    width_reg = 31'd1;
    used_reg = 9'(USE_RESET);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty reads, extremes, underflow and overflow
    add_row(mk(OP_READ, 32'd0, 8'd0), 1'b1, rd_empty(8'd0));
    add_row(mk(OP_READ, 32'd0, 8'd255), 1'b1, rd_empty(8'd255));
    w = '0; w.underflow_count = 32'd1;
    add_row(mk(OP_ADD, 32'h8000_0000, 8'd0), 1'b1, w);
    w.underflow_count = 32'd2;
    add_row(mk(OP_ADD, 32'hFFFF_FFFF, 8'd0), 1'b1, w);
    w.overflow_count = 32'd1;
    add_row(mk(OP_ADD, 32'h7FFF_FFFF, 8'd0), 1'b1, w);
    w.overflow_count = 32'd2;
    add_row(mk(OP_ADD, 32'd256, 8'd0), 1'b1, w);
    add_row(mk(OP_ADD, 32'd0, 8'd0), 1'b0, w);
    add_row(mk(OP_ADD, 32'd255, 8'd0), 1'b0, w);
    add_row(mk(OP_ADD, 32'd1, 8'hFF), 1'b0, w);
    add_row(mk(OP_READ, 32'hFFFF_FFFF, 8'd0), 1'b0, w);
    add_row(mk(OP_READ, 32'd0, 8'd1), 1'b0, w);
    add_row(mk(OP_READ, 32'd0, 8'd255), 1'b0, w);
    add_row(mk(OP_READ, 32'd0, 8'd128), 1'b0, w);
    run_table();
    drain();

    // largest width, a single bin in use
    write_reg(REG_BIN_WIDTH, 31'h7FFF_FFFF);
    write_reg(REG_BINS_IN_USE, 31'd1);
    send_request(mk(OP_ADD, 32'h7FFF_FFFE, 8'd0));
    send_request(mk(OP_ADD, 32'h7FFF_FFFF, 8'd0));
    send_request(mk(OP_READ, 32'd0, 8'd255));
    send_request(mk(OP_READ, 32'd0, 8'd0));
    drain();
    // zero width and zero bins in use
    write_reg(REG_BIN_WIDTH, 31'd0);
    write_reg(REG_BINS_IN_USE, 31'd0);
    send_request(mk(OP_ADD, 32'd0, 8'd0));
    send_request(mk(OP_READ, 32'd0, 8'd0));
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_reg(REG_BIN_WIDTH, 31'd3); write_reg(REG_BINS_IN_USE, 31'd16); end
        1: begin write_reg(REG_BIN_WIDTH, 31'd1000); write_reg(REG_BINS_IN_USE, 31'd256); end
        2: begin
          write_reg(REG_BIN_WIDTH, 31'($urandom_range(1, 32'h7FFF_FFFF)));
          write_reg(REG_BINS_IN_USE, 31'($urandom_range(0, 511)));
        end
        default: begin write_reg(REG_BIN_WIDTH, 31'd1); write_reg(REG_BINS_IN_USE, 31'd300); end
      endcase
      if (ph == 3) quiet = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        send_request(random_request(ph == 1 ? 0 : ($urandom_range(0, 1))));
        // hold off once until everything is back
        if (ph == 1 && n == 40) while (result_queue.size() != 0) @(posedge clk);
      end
      drain();
    end

    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
